FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GFQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gfq assertion failed");

`endif

FILE: hw/rtl/gfq_pkg.sv
// Types and constants of the genotype filter query engine.
`timescale 1ns / 1ps

package gfq_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] MODE_COUNT  = 2'd0;
  localparam logic [1:0] MODE_ALLELE = 2'd1;
  localparam logic [1:0] MODE_SCORE  = 2'd2;
  localparam logic [1:0] MODE_SIMIL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONJUNCTIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIM_THRESH  = 2'd3;

  localparam logic [31:0] ALLELE_COPIES = 32'd2;

  localparam logic RESULT_SCORE  = 1'b0;
  localparam logic RESULT_TOTALS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

endpackage

FILE: hw/rtl/gfq_mul.sv
// Shared 32x32 multiplier with registered low product.
`timescale 1ns / 1ps

module gfq_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [31:0] prod_r
);

  logic [63:0] full_prod;
  logic [31:0] prod_nxt;

  assign full_prod = op_a * op_b;
  assign prod_nxt  = en ? full_prod[31:0] : prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: hw/rtl/genotype_filter_query_engine.sv
// Genotype filter query engine: filter, allele, risk score and similarity queries.
// Each input item passes the multiply step, then the update step that loads its result.
// A new input item is taken only in idle, after the shared multiplier pass and update of the last.
// A pending result that is not taken holds the update step until the output frees.
// Reset (synchronous, active low) loads register defaults and clears all totals.
`timescale 1ns / 1ps

module genotype_filter_query_engine
  import gfq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_genotype,
  input  logic signed [31:0]   in_term_value,
  input  logic                 in_is_target,
  input  logic                 in_last_of_patient,
  input  logic                 in_last_of_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output logic [30:0]          out_patient_number,
  output logic signed [31:0]   out_risk_score,
  output logic [30:0]          out_match_count,
  output logic signed [31:0]   out_allele_result,
  output logic [30:0]          out_yes_count,
  output logic [30:0]          out_no_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  state_t state_r, state_nxt;

  logic [1:0]  mode_r, mode_nxt;
  logic        conj_r, conj_nxt;
  logic [30:0] row_r, row_nxt;
  logic [31:0] thr_r, thr_nxt;

  logic        pass_r, pass_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [30:0] idx_r, idx_nxt;
  logic [31:0] pt_r, pt_nxt;
  logic [31:0] at_r, at_nxt;
  logic [31:0] yt_r, yt_nxt;
  logic [31:0] nt_r, nt_nxt;

  logic        out_valid_r, out_valid_nxt;

  logic [7:0]  g_r, g_nxt;
  logic [31:0] tv_r, tv_nxt;
  logic        tgt_r, tgt_nxt;
  logic        lp_r, lp_nxt;
  logic        ld_r, ld_nxt;

  logic        kind_r, kind_nxt;
  logic [30:0] pnum_r, pnum_nxt;
  logic [31:0] score_r, score_nxt;
  logic [30:0] match_r, match_nxt;
  logic [31:0] allele_r, allele_nxt;
  logic [30:0] yes_r, yes_nxt;
  logic [30:0] no_r, no_nxt;

  logic [31:0] mul_a, mul_b, prod_r, diff, g_ext;
  logic        mul_en;

  assign g_ext = {24'd0, g_r};
  assign diff  = g_ext - tv_r;

  always_comb begin
    unique case (mode_r)
      MODE_SCORE: begin
        mul_a = tv_r;
        mul_b = g_ext;
      end
      MODE_SIMIL: begin
        mul_a = diff;
        mul_b = diff;
      end
      MODE_COUNT, MODE_ALLELE: begin
        mul_a = (tgt_r && pass_r) ? (at_r + g_ext) : at_r;
        mul_b = {row_r, 1'b0};
      end
    endcase
  end

  assign mul_en = (state_r == ST_MUL);

  gfq_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  always_comb begin
    logic        t_pass;
    logic [31:0] t_acc;
    logic [31:0] t_pt;
    logic [31:0] t_at;
    logic [31:0] t_yt;
    logic [31:0] t_nt;
    logic        last_p;
    logic        emit_score;
    logic        emit_tot;

    state_nxt     = state_r;
    mode_nxt      = mode_r;
    conj_nxt      = conj_r;
    row_nxt       = row_r;
    thr_nxt       = thr_r;
    pass_nxt      = pass_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    pt_nxt        = pt_r;
    at_nxt        = at_r;
    yt_nxt        = yt_r;
    nt_nxt        = nt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    g_nxt         = g_r;
    tv_nxt        = tv_r;
    tgt_nxt       = tgt_r;
    lp_nxt        = lp_r;
    ld_nxt        = ld_r;
    kind_nxt      = kind_r;
    pnum_nxt      = pnum_r;
    score_nxt     = score_r;
    match_nxt     = match_r;
    allele_nxt    = allele_r;
    yes_nxt       = yes_r;
    no_nxt        = no_r;

    t_pass     = pass_r;
    t_acc      = acc_r;
    t_pt       = pt_r;
    t_at       = at_r;
    t_yt       = yt_r;
    t_nt       = nt_r;
    last_p     = lp_r || ld_r;
    emit_score = 1'b0;
    emit_tot   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          unique case (cfg_index)
            CFG_QUERY_MODE:  mode_nxt = cfg_data[1:0];
            CFG_CONJUNCTIVE: begin
              conj_nxt = cfg_data[0];
              pass_nxt = cfg_data[0];
            end
            CFG_ROW_COUNT:   row_nxt = cfg_data[30:0];
            CFG_SIM_THRESH:  thr_nxt = cfg_data;
          endcase
        end
        if (in_valid) begin
          g_nxt     = in_genotype;
          tv_nxt    = in_term_value;
          tgt_nxt   = in_is_target;
          lp_nxt    = in_last_of_patient;
          ld_nxt    = in_last_of_data;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!tgt_r) begin
          unique case (mode_r)
            MODE_COUNT, MODE_ALLELE: begin
              if (conj_r) begin
                if (tv_r != g_ext) t_pass = 1'b0;
              end else begin
                if (tv_r == g_ext) t_pass = 1'b1;
              end
            end
            MODE_SCORE, MODE_SIMIL: t_acc = acc_r + prod_r;
          endcase
        end else begin
          if (mode_r == MODE_ALLELE && pass_r) begin
            t_at = at_r + g_ext;
            t_pt = pt_r + ALLELE_COPIES;
          end else if (mode_r == MODE_SIMIL && acc_r < thr_r) begin
            t_yt = yt_r + g_ext;
            t_nt = nt_r + (32'd1 - g_ext);
          end
        end

        if (last_p && mode_r == MODE_SCORE && idx_r < row_r) emit_score = 1'b1;
        emit_tot = ld_r && !emit_score;

        if ((emit_score || emit_tot) && out_valid_r && !out_ready) begin
          state_nxt = ST_UPD;
        end else begin
          state_nxt = ST_IDLE;
          if (last_p && mode_r == MODE_COUNT && t_pass) t_pt = t_pt + 32'd1;

          if (emit_score || emit_tot) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = emit_score ? RESULT_SCORE : RESULT_TOTALS;
            pnum_nxt      = emit_score ? idx_r : 31'd0;
            score_nxt     = emit_score ? t_acc : 32'd0;
            match_nxt     = (emit_tot && mode_r == MODE_COUNT) ? t_pt[30:0] : 31'd0;
            allele_nxt    = (emit_tot && mode_r == MODE_ALLELE) ? (t_pt + prod_r) : 32'd0;
            yes_nxt       = (emit_tot && mode_r == MODE_SIMIL) ? t_yt[30:0] : 31'd0;
            no_nxt        = (emit_tot && mode_r == MODE_SIMIL) ? t_nt[30:0] : 31'd0;
          end

          pass_nxt = t_pass;
          acc_nxt  = t_acc;
          pt_nxt   = t_pt;
          at_nxt   = t_at;
          yt_nxt   = t_yt;
          nt_nxt   = t_nt;
          if (last_p) begin
            acc_nxt  = 32'd0;
            pass_nxt = conj_r;
            idx_nxt  = idx_r + 31'd1;
          end
          if (ld_r) begin
            idx_nxt = 31'd0;
            pt_nxt  = 32'd0;
            at_nxt  = 32'd0;
            yt_nxt  = 32'd0;
            nt_nxt  = 32'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_COUNT;
      conj_r      <= 1'b1;
      row_r       <= 31'd0;
      thr_r       <= 32'd0;
      pass_r      <= 1'b1;
      acc_r       <= 32'd0;
      idx_r       <= 31'd0;
      pt_r        <= 32'd0;
      at_r        <= 32'd0;
      yt_r        <= 32'd0;
      nt_r        <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      conj_r      <= conj_nxt;
      row_r       <= row_nxt;
      thr_r       <= thr_nxt;
      pass_r      <= pass_nxt;
      acc_r       <= acc_nxt;
      idx_r       <= idx_nxt;
      pt_r        <= pt_nxt;
      at_r        <= at_nxt;
      yt_r        <= yt_nxt;
      nt_r        <= nt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r      <= g_nxt;
    tv_r     <= tv_nxt;
    tgt_r    <= tgt_nxt;
    lp_r     <= lp_nxt;
    ld_r     <= ld_nxt;
    kind_r   <= kind_nxt;
    pnum_r   <= pnum_nxt;
    score_r  <= score_nxt;
    match_r  <= match_nxt;
    allele_r <= allele_nxt;
    yes_r    <= yes_nxt;
    no_r     <= no_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign cfg_ready          = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_patient_number = pnum_r;
  assign out_risk_score     = score_r;
  assign out_match_count    = match_r;
  assign out_allele_result  = allele_r;
  assign out_yes_count      = yes_r;
  assign out_no_count       = no_r;

endmodule

FILE: hw/rtl/gfq_checker.sv
// Port-level checker for the genotype filter query engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gfq_checker
  import gfq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [30:0] out_patient_number,
  input logic [31:0] out_risk_score,
  input logic [30:0] out_match_count,
  input logic [31:0] out_allele_result,
  input logic [30:0] out_yes_count,
  input logic [30:0] out_no_count
);

  logic score_seen;
  logic totals_seen;
  logic totals_fields_zero;
  logic score_fields_zero;

  assign score_seen         = out_valid && out_result_kind == RESULT_SCORE;
  assign totals_seen        = out_valid && out_result_kind == RESULT_TOTALS;
  assign totals_fields_zero = out_match_count == 31'd0 && out_allele_result == 32'd0 &&
                              out_yes_count == 31'd0 && out_no_count == 31'd0;
  assign score_fields_zero  = out_patient_number == 31'd0 && out_risk_score == 32'd0;

  `GFQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `GFQ_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready)
  `GFQ_ASSERT_SAME(a_score_fields, clk, rst_n, score_seen, totals_fields_zero)
  `GFQ_ASSERT_SAME(a_totals_fields, clk, rst_n, totals_seen, score_fields_zero)

endmodule

bind genotype_filter_query_engine gfq_checker u_gfq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_kind    (out_result_kind),
  .out_patient_number (out_patient_number),
  .out_risk_score     (out_risk_score),
  .out_match_count    (out_match_count),
  .out_allele_result  (out_allele_result),
  .out_yes_count      (out_yes_count),
  .out_no_count       (out_no_count)
);

FILE: verif/genotype_query_checker.sv
// Scoreboard for the genotype filter query engine: tracks transfers, predicts results, compares.
`timescale 1ns / 1ps

module genotype_query_checker
  import gfq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_genotype,
  input  logic [31:0]          in_term_value,
  input  logic                 in_is_target,
  input  logic                 in_last_of_patient,
  input  logic                 in_last_of_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_result_kind,
  input  logic [30:0]          out_patient_number,
  input  logic [31:0]          out_risk_score,
  input  logic [30:0]          out_match_count,
  input  logic [31:0]          out_allele_result,
  input  logic [30:0]          out_yes_count,
  input  logic [30:0]          out_no_count,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int unsigned          fail_count,
  output int unsigned          pending
);

  typedef struct packed {
    logic        kind;
    logic [30:0] patient;
    logic [31:0] score;
    logic [30:0] match_cnt;
    logic [31:0] alleles;
    logic [30:0] yes;
    logic [30:0] no;
  } query_result_t;

  query_result_t results_due[$];

  logic [1:0]  mode;
  logic        conj;
  logic [30:0] rows;
  logic [31:0] threshold;

  logic        passing;
  logic [31:0] patient_sum;
  logic [30:0] patient_idx;
  logic [31:0] pass_sum;
  logic [31:0] allele_sum;
  logic [31:0] yes_sum;
  logic [31:0] no_sum;

  task automatic clear_totals();
    passing     = conj;
    patient_sum = '0;
    patient_idx = '0;
    pass_sum    = '0;
    allele_sum  = '0;
    yes_sum     = '0;
    no_sum      = '0;
  endtask

  task automatic apply_register_write();
    case (cfg_index)
      CFG_QUERY_MODE: mode = cfg_data[1:0];
      CFG_CONJUNCTIVE: begin
        conj    = cfg_data[0];
        passing = cfg_data[0];
      end
      CFG_ROW_COUNT: rows = cfg_data[30:0];
      default: threshold = cfg_data;
    endcase
  endtask

  task automatic step_query(input logic [7:0] geno, input logic [31:0] term, input logic tgt,
                            input logic close_patient, input logic close_data);
    logic [31:0]   g;
    logic [31:0]   diff;
    logic          scored;
    query_result_t res;
    g      = {24'd0, geno};
    scored = 1'b0;
    if (!tgt) begin
      case (mode)
        MODE_COUNT, MODE_ALLELE: begin
          if (conj && term != g) passing = 1'b0;
          else if (!conj && term == g) passing = 1'b1;
        end
        MODE_SCORE: patient_sum = patient_sum + term * g;
        default: begin
          diff        = g - term;
          patient_sum = patient_sum + diff * diff;
        end
      endcase
    end else if (mode == MODE_ALLELE && passing) begin
      allele_sum = allele_sum + g;
      pass_sum   = pass_sum + ALLELE_COPIES;
    end else if (mode == MODE_SIMIL && patient_sum < threshold) begin
      yes_sum = yes_sum + g;
      no_sum  = no_sum + (32'd1 - g);
    end

    if (close_patient) begin
      if (mode == MODE_COUNT && passing) pass_sum = pass_sum + 32'd1;
      if (mode == MODE_SCORE && patient_idx < rows) begin
        res         = '0;
        res.kind    = RESULT_SCORE;
        res.patient = patient_idx;
        res.score   = patient_sum;
        results_due.push_back(res);
        scored = 1'b1;
      end
      patient_sum = '0;
      passing     = conj;
      patient_idx = patient_idx + 31'd1;
    end

    if (close_data) begin
      if (!scored) begin
        res      = '0;
        res.kind = RESULT_TOTALS;
        case (mode)
          MODE_COUNT: res.match_cnt = pass_sum[30:0];
          MODE_ALLELE: res.alleles = pass_sum + allele_sum * (ALLELE_COPIES * {1'b0, rows});
          MODE_SIMIL: begin
            res.yes = yes_sum[30:0];
            res.no  = no_sum[30:0];
          end
          default: ;
        endcase
        results_due.push_back(res);
      end
      clear_totals();
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) $display("checker: %s expected %h got %h", field, want, got);
    end
  endtask

  task automatic check_result();
    query_result_t want;
    if (results_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("checker: unexpected result of kind %0d", out_result_kind);
    end else begin
      want = results_due.pop_front();
      check_field("result_kind", 32'(want.kind), 32'(out_result_kind));
      check_field("patient_number", 32'(want.patient), 32'(out_patient_number));
      check_field("risk_score", want.score, out_risk_score);
      check_field("match_count", 32'(want.match_cnt), 32'(out_match_count));
      check_field("allele_result", want.alleles, out_allele_result);
      check_field("yes_count", 32'(want.yes), 32'(out_yes_count));
      check_field("no_count", 32'(want.no), 32'(out_no_count));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode      = MODE_COUNT;
      conj      = 1'b1;
      rows      = '0;
      threshold = '0;
      clear_totals();
      results_due.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) apply_register_write();
      if (in_valid && in_ready)
        step_query(in_genotype, in_term_value, in_is_target,
                   in_last_of_patient || in_last_of_data, in_last_of_data);
    end
    pending <= results_due.size();
  end

endmodule

FILE: verif/testbench.sv
// Top-level testbench of the genotype filter query engine: stimulus, idling and verdict.
`timescale 1ns / 1ps

module testbench;
  import gfq_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STUCK_LIMIT     = 3000;
  localparam int ITEM_TARGET     = 1700;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 20;
  localparam int NO_PAUSE        = -1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_genotype = '0;
  logic signed [31:0]   in_term_value = '0;
  logic                 in_is_target = 1'b0;
  logic                 in_last_of_patient = 1'b0;
  logic                 in_last_of_data = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_result_kind;
  logic [30:0]          out_patient_number;
  logic signed [31:0]   out_risk_score;
  logic [30:0]          out_match_count;
  logic signed [31:0]   out_allele_result;
  logic [30:0]          out_yes_count;
  logic [30:0]          out_no_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned stuck_cycles = 0;
  logic [1:0]  cur_mode = MODE_COUNT;
  bit          quiet_stretch = 1'b0;
  bit          hold_pending = 1'b0;

  always #5 clk = ~clk;

  genotype_filter_query_engine dut (.*);

  genotype_query_checker u_checker (.*);

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_stretch || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] g, input logic [31:0] tv, input logic tgt,
                           input logic lastp, input logic lastd);
    if (!quiet_stretch && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_genotype        <= g;
    in_term_value      <= tv;
    in_is_target       <= tgt;
    in_last_of_patient <= lastp;
    in_last_of_data    <= lastd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    if (idx == CFG_QUERY_MODE) cur_mode = data[1:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_genotype();
    return ($urandom_range(3) != 0) ? 8'($urandom_range(2)) : 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_target();
    if (cur_mode == MODE_SIMIL && $urandom_range(3) != 0) return 8'($urandom_range(1));
    return pick_genotype();
  endfunction

  function automatic logic [31:0] pick_term(input logic [7:0] g);
    int unsigned roll;
    roll = $urandom_range(99);
    case (cur_mode)
      MODE_SCORE: return (roll < 60) ? $urandom : 32'($urandom_range(3)) - 32'd1;
      MODE_SIMIL: return (roll < 60) ? {24'd0, g} + 32'($urandom_range(4)) - 32'd2 : $urandom;
      default: begin
        if (roll < 50) return {24'd0, g};
        return (roll < 80) ? 32'($urandom_range(2)) : $urandom;
      end
    endcase
  endfunction

  task automatic program_random_setup();
    int unsigned roll;
    cfg_write(CFG_QUERY_MODE, 32'($urandom_range(3)));
    if ($urandom_range(3) != 0) cfg_write(CFG_CONJUNCTIVE, 32'($urandom_range(1)));
    if ($urandom_range(3) != 0) begin
      roll = $urandom_range(9);
      cfg_write(CFG_ROW_COUNT, (roll == 0) ? 32'd0 :
                               (roll == 1) ? 32'h7FFF_FFFF : 32'($urandom_range(24)));
    end
    if ($urandom_range(3) != 0) begin
      roll = $urandom_range(9);
      cfg_write(CFG_SIM_THRESH, (roll == 0) ? 32'd0 :
                                (roll == 1) ? 32'hFFFF_FFFF :
                                (roll < 7)  ? 32'($urandom_range(60)) : $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // One query: patient groups of filter terms then target; sometimes noise or no end marker.
  task automatic run_query(input int patients, input int pause_at);
    int         p;
    int         k;
    int         n_terms;
    int         n_targets;
    int         len;
    bit         ends_data;
    logic [7:0] g;
    logic       lastd;
    ends_data = ($urandom_range(9) != 0);
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 4))
        send_item(8'($urandom_range(255)), $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom_range(7) == 0);
    for (p = 0; p < patients; p++) begin
      if (p == pause_at) drain_results();
      n_terms = $urandom_range(4);
      case ($urandom_range(19))
        0: n_targets = 0;
        1: n_targets = 2;
        default: n_targets = 1;
      endcase
      if (n_terms + n_targets == 0) n_terms = 1;
      len = n_terms + n_targets;
      for (k = 0; k < len; k++) begin
        g     = (k >= n_terms) ? pick_target() : pick_genotype();
        lastd = ends_data && (p == patients - 1) && (k == len - 1);
        send_item(g, pick_term(g), k >= n_terms,
                  (k == len - 1) && !(lastd && $urandom_range(3) == 0), lastd);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // count, all terms: match, mismatch, empty filter
    send_item(8'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(8'd255, 32'd0, 1'b1, 1'b1, 1'b0);
    send_item(8'd255, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_item(8'd0, 32'd0, 1'b1, 1'b1, 1'b0);
    send_item(8'd1, 32'd0, 1'b1, 1'b1, 1'b1);

    // allele sum, any term, widest row count
    quiesce();
    cfg_write(CFG_QUERY_MODE, 32'(MODE_ALLELE));
    cfg_write(CFG_CONJUNCTIVE, 32'd0);
    cfg_write(CFG_ROW_COUNT, 32'h7FFF_FFFF);
    cfg_valid <= 1'b0;
    send_item(8'd2, 32'd2, 1'b0, 1'b0, 1'b0);
    send_item(8'd1, 32'd0, 1'b1, 1'b1, 1'b0);
    send_item(8'd1, 32'd7, 1'b0, 1'b0, 1'b0);
    send_item(8'd2, 32'd0, 1'b1, 1'b1, 1'b0);
    send_item(8'd2, 32'd0, 1'b1, 1'b0, 1'b1);

    // risk score with a single real patient
    quiesce();
    cfg_write(CFG_QUERY_MODE, 32'(MODE_SCORE));
    cfg_write(CFG_ROW_COUNT, 32'd1);
    cfg_valid <= 1'b0;
    send_item(8'd255, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_item(8'd200, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
    send_item(8'd9, 32'd0, 1'b1, 1'b1, 1'b0);
    send_item(8'd3, 32'hFFFF_FFFD, 1'b0, 1'b0, 1'b1);

    // similarity, widest threshold, non-binary phenotype
    quiesce();
    cfg_write(CFG_QUERY_MODE, 32'(MODE_SIMIL));
    cfg_write(CFG_SIM_THRESH, 32'hFFFF_FFFF);
    cfg_write(CFG_CONJUNCTIVE, 32'd1);
    cfg_valid <= 1'b0;
    send_item(8'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
    send_item(8'd1, 32'd0, 1'b1, 1'b1, 1'b0);
    send_item(8'd7, 32'd0, 1'b0, 1'b0, 1'b0);
    send_item(8'd0, 32'd0, 1'b1, 1'b1, 1'b0);
    send_item(8'd5, 32'd0, 1'b1, 1'b1, 1'b1);

    // back up the result side, then pause mid-query until drained
    quiesce();
    cfg_write(CFG_QUERY_MODE, 32'(MODE_SCORE));
    cfg_write(CFG_ROW_COUNT, 32'h7FFF_FFFF);
    cfg_valid <= 1'b0;
    hold_pending = 1'b1;
    run_query(24, NO_PAUSE);
    run_query(10, 4);

    while (items_sent < ITEM_TARGET) begin
      quiesce();
      quiet_stretch = (items_sent >= 700 && items_sent < 1000);
      program_random_setup();
      repeat ($urandom_range(2, 4))
        run_query(($urandom_range(9) < 7) ? $urandom_range(2, 8) : $urandom_range(9, 20),
                  NO_PAUSE);
    end
    quiet_stretch = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
